/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset
`define GMCP_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition never holds outside reset
`define GMCP_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

/* hw/rtl/gmcp_pkg.sv */
// ----------------------------------------------------------------------------
// gmcp_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gmcp_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;
	localparam int HEIGHT_W     = 4;
	localparam int HEIGHT_MAX   = (1 << HEIGHT_W) - 1;
	localparam int COST_W       = 11;
	localparam int COST_SAT     = (1 << COST_W) - 1;
	localparam int CFG_W        = 7;
	localparam int CFG_IDX_W    = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

	// per-cell relax sequence
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_SELF  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_UP    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_RIGHT = 3'd2;
	localparam logic [STEP_W-1:0] STEP_DOWN  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_LEFT  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_DONE  = 3'd5;

	typedef struct packed {
		logic              load_wr;
		logic              init_start;
		logic              init_wr;
		logic              sweep_start;
		logic              sweep;
		logic [STEP_W-1:0] step;
		logic              cell_next;
		logic              capture;
	} gmcp_cmd_t;

	typedef struct packed {
		logic at_last;
		logic changed;
		logic out_busy;
	} gmcp_stat_t;

endpackage

/* hw/rtl/gmcp_datapath.sv */
// ----------------------------------------------------------------------------
// gmcp_datapath
// Height and distance memories, cell counters, relax arithmetic, result reg.
// ----------------------------------------------------------------------------
module gmcp_datapath import gmcp_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [HEIGHT_W-1:0]  cell_height,
	input  logic                 last_cell,
	input  gmcp_cmd_t            cmd,
	output gmcp_stat_t           stat,
	output logic [COST_W-1:0]    path_cost,
	output logic                 out_valid,
	input  logic                 out_ready
);

	localparam int CAP = MAX_ROWS * MAX_COLS;
	localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int NW  = $clog2(CAP + 1);
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RDW = $clog2(MAX_ROWS + 1);
	localparam int CDW = $clog2(MAX_COLS + 1);
	localparam int RCW = (RDW > CFG_W) ? RDW : CFG_W;
	localparam int CCW = (CDW > CFG_W) ? CDW : CFG_W;
	localparam int DW  = $clog2(CAP * HEIGHT_MAX + 1) + 1;
	localparam int SW  = (DW > COST_W) ? DW : COST_W;
	localparam logic [DW-1:0] DIST_INF = {DW{1'b1}};

	logic [CFG_W-1:0]    row_q, col_q;
	logic [RCW-1:0]      row_ext;
	logic [CCW-1:0]      col_ext;
	logic [RDW-1:0]      rows_c;
	logic [CDW-1:0]      cols_c;
	logic [NW-1:0]       n_cells;
	logic [AW-1:0]       last_idx;
	logic [AW-1:0]       idx_q, load_pos_q, rd_addr;
	logic [RW-1:0]       r_q;
	logic [CW-1:0]       c_q;
	logic                r_last, c_last, nbv, nbv_q;
	logic [HEIGHT_W-1:0] hmem [CAP];
	logic [DW-1:0]       dmem [CAP];
	logic [HEIGHT_W-1:0] h_rd_q, own_h_q, hdiff;
	logic [DW-1:0]       d_rd_q, own_d_q, best_q, cand, best_nx;
	logic [SW-1:0]       d_ext;
	logic                take, upd_wr, changed_q, out_valid_q;
	logic [COST_W-1:0]   out_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= CFG_W'(1);
			col_q <= CFG_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_ROW_COUNT) row_q <= cfg_data;
			if (cfg_index == REG_COL_COUNT) col_q <= cfg_data;
		end
	end

	// clamp grid size into 1..MAX
	always_comb begin
		row_ext = RCW'(row_q);
		col_ext = CCW'(col_q);
		if (row_ext == '0) rows_c = RDW'(1);
		else if (row_ext > RCW'(MAX_ROWS)) rows_c = RDW'(MAX_ROWS);
		else rows_c = RDW'(row_ext);
		if (col_ext == '0) cols_c = CDW'(1);
		else if (col_ext > CCW'(MAX_COLS)) cols_c = CDW'(MAX_COLS);
		else cols_c = CDW'(col_ext);
	end

	assign n_cells  = NW'(rows_c) * NW'(cols_c);
	assign last_idx = AW'(n_cells - NW'(1));
	assign r_last   = (RDW'(r_q) == rows_c - RDW'(1));
	assign c_last   = (CDW'(c_q) == cols_c - CDW'(1));

	// read address: self or one neighbor, else the goal cell
	always_comb begin
		rd_addr = last_idx;
		nbv     = 1'b0;
		if (cmd.sweep) begin
			case (cmd.step)
				STEP_SELF: begin
					rd_addr = idx_q;
					nbv     = 1'b1;
				end
				STEP_UP: begin
					rd_addr = idx_q - AW'(cols_c);
					nbv     = (r_q != '0);
				end
				STEP_RIGHT: begin
					rd_addr = idx_q + AW'(1);
					nbv     = !c_last;
				end
				STEP_DOWN: begin
					rd_addr = idx_q + AW'(cols_c);
					nbv     = !r_last;
				end
				STEP_LEFT: begin
					rd_addr = idx_q - AW'(1);
					nbv     = (c_q != '0);
				end
				default: begin
					rd_addr = idx_q;
					nbv     = 1'b0;
				end
			endcase
		end
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (cmd.load_wr) hmem[load_pos_q] <= cell_height;
		h_rd_q <= hmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_wr) dmem[idx_q] <= (idx_q == '0) ? '0 : DIST_INF;
		else if (upd_wr) dmem[idx_q] <= best_nx;
		d_rd_q <= dmem[rd_addr];
	end

	// relax: candidate from the neighbor read last cycle
	always_comb begin
		hdiff   = (h_rd_q > own_h_q) ? (h_rd_q - own_h_q) : (own_h_q - h_rd_q);
		cand    = d_rd_q + DW'(hdiff);
		take    = nbv_q && (d_rd_q != DIST_INF) && (cand < best_q);
		best_nx = take ? cand : best_q;
		upd_wr  = cmd.sweep && (cmd.step == STEP_DONE) && (best_nx < own_d_q);
	end

	always_ff @(posedge clk) begin
		nbv_q <= nbv;
		if (cmd.sweep) begin
			case (cmd.step)
				STEP_UP: begin
					own_h_q <= h_rd_q;
					own_d_q <= d_rd_q;
					best_q  <= d_rd_q;
				end
				STEP_RIGHT, STEP_DOWN, STEP_LEFT: best_q <= best_nx;
				default: ;
			endcase
		end
	end

	// cell counters, load pointer, change flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			r_q        <= '0;
			c_q        <= '0;
			load_pos_q <= '0;
			changed_q  <= 1'b0;
		end else begin
			if (cmd.init_start || cmd.sweep_start) begin
				idx_q <= '0;
				r_q   <= '0;
				c_q   <= '0;
			end else if (cmd.init_wr) begin
				idx_q <= idx_q + AW'(1);
			end else if (cmd.cell_next) begin
				idx_q <= idx_q + AW'(1);
				if (c_last) begin
					c_q <= '0;
					r_q <= r_q + RW'(1);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
			if (cmd.load_wr) begin
				if (last_cell || load_pos_q == AW'(CAP - 1)) load_pos_q <= '0;
				else load_pos_q <= load_pos_q + AW'(1);
			end
			if (cmd.sweep_start) changed_q <= 1'b0;
			else if (upd_wr) changed_q <= 1'b1;
		end
	end

	// result register, saturated
	assign d_ext = SW'(d_rd_q);

	always_ff @(posedge clk) begin
		if (cmd.capture)
			out_q <= (d_ext > SW'(COST_SAT)) ? COST_W'(COST_SAT) : COST_W'(d_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.capture) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign path_cost     = out_q;
	assign out_valid     = out_valid_q;
	assign stat.at_last  = (idx_q == last_idx);
	assign stat.changed  = changed_q | upd_wr;
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule

/* hw/rtl/gmcp_ctrl.sv */
// ----------------------------------------------------------------------------
// gmcp_ctrl
// Sequencer: load, distance init, relax sweeps to a fixed point, result.
// ----------------------------------------------------------------------------
module gmcp_ctrl import gmcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       last_cell,
	output logic       in_ready,
	input  gmcp_stat_t stat,
	output gmcp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_SWEEP,
		ST_FETCH,
		ST_CAPTURE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              cell_end;

	assign in_ready = (state_q == ST_LOAD);
	assign cell_end = (state_q == ST_SWEEP) && (step_q == STEP_DONE);

	// command decode
	always_comb begin
		cmd             = '0;
		cmd.load_wr     = in_ready && in_valid;
		cmd.init_start  = in_ready && in_valid && last_cell;
		cmd.init_wr     = (state_q == ST_INIT);
		cmd.sweep_start = ((state_q == ST_INIT) && stat.at_last)
			|| (cell_end && stat.at_last && stat.changed);
		cmd.sweep       = (state_q == ST_SWEEP);
		cmd.step        = step_q;
		cmd.cell_next   = cell_end && !stat.at_last;
		cmd.capture     = (state_q == ST_CAPTURE) && !stat.out_busy;
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= STEP_SELF;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_valid && last_cell) state_q <= ST_INIT;
				end
				ST_INIT: begin
					step_q <= STEP_SELF;
					if (stat.at_last) state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (step_q == STEP_DONE) begin
						step_q <= STEP_SELF;
						if (stat.at_last && !stat.changed) state_q <= ST_FETCH;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_FETCH: state_q <= ST_CAPTURE;
				ST_CAPTURE: begin
					if (!stat.out_busy) state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

/* hw/rtl/grid_min_climb_path.sv */
// ----------------------------------------------------------------------------
// grid_min_climb_path
// Least-climb path cost over a loaded height grid, 4-neighbor moves.
// ----------------------------------------------------------------------------
// Usage:
//  Set row_count / col_count through the cfg port while idle. Stream cell
//  heights in raster order on the in channel, one beat per cycle; the beat
//  with last_cell high starts the search. Only that beat yields a result,
//  one beat on the out channel carrying path_cost (saturated at 2047).
//  Search: distance init over all N = rows*cols cells, then relax sweeps
//  (one memory read port; each cell reads itself and its four neighbors)
//  until a sweep changes nothing; then the goal cell is read and captured.
//  The sweep count is at most the longest settled path length plus one.
//  in_ready is low from the last cell until the result is registered.
//  A stalled receiver holds the result; new cells load meanwhile, and the
//  next search waits at its end until the output register frees up.
//  Reset: grid 1x1, load pointer zero; heights stay undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_min_climb_path import gmcp_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [HEIGHT_W-1:0]  cell_height,
	input  logic                 last_cell,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COST_W-1:0]    path_cost
);

	gmcp_cmd_t  cmd;
	gmcp_stat_t stat;

	gmcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_cell (last_cell),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gmcp_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cell_height (cell_height),
		.last_cell   (last_cell),
		.cmd         (cmd),
		.stat        (stat),
		.path_cost   (path_cost),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

	// a result only appears after a search, never straight from loading
	`GMCP_ASSERT(a_result_after_search, clk, arst_n, $rose(out_valid) |-> $past(!in_ready))
	// the last cell closes the input until the search ends
	`GMCP_ASSERT(a_last_blocks_input, clk, arst_n, in_valid && in_ready && last_cell |=> !in_ready)
	// loading and sweeping never overlap
	`GMCP_NEVER(a_load_in_sweep, clk, arst_n, cmd.load_wr && (cmd.sweep || cmd.init_wr))

endmodule

/* tb/grid_min_climb_path_checker.sv */
// ----------------------------------------------------------------------------
// grid_min_climb_path_checker
// Watches the cfg, cell and cost channels of the block, keeps its own copy
// of the grid and settings, and computes the least-climb cost when the last
// cell beat goes in. Each cost beat that comes out is compared with the
// oldest pending cost.
// ----------------------------------------------------------------------------
module grid_min_climb_path_checker import gmcp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [HEIGHT_W-1:0]  cell_height,
	input  logic                 last_cell,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [COST_W-1:0]    path_cost,
	output int                   fail_count,
	output int                   cost_pending
);

	localparam int CAP = DEF_MAX_ROWS * DEF_MAX_COLS;
	localparam int AW  = $clog2(CAP);

	logic [HEIGHT_W-1:0] grid_heights [CAP];
	logic [AW-1:0]       write_pos;
	logic [CFG_W-1:0]    rows_reg;
	logic [CFG_W-1:0]    cols_reg;
	logic [COST_W-1:0]   cost_fifo [4];
	logic [1:0]          head_q;
	logic [1:0]          tail_q;
	int                  pend_q;
	logic                in_beat;
	logic                out_beat;
	logic                push;
	logic                pop;

	function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : int'(v);
	endfunction

	// Dijkstra over the grid in use, 4-neighbor moves, climb cost per move
	function automatic logic [COST_W-1:0] climb_cost();
		int  rows, cols, total, best, best_d, r, c, nr, nc, nidx, cand, k, hb, hn;
		int  cost_to [CAP];
		bit  closed [CAP];
		int  dr [4];
		int  dc [4];
		rows  = clamp_dim(rows_reg, DEF_MAX_ROWS);
		cols  = clamp_dim(cols_reg, DEF_MAX_COLS);
		total = rows * cols;
		dr = '{-1, 0, 1, 0};
		dc = '{0, 1, 0, -1};
		for (int i = 0; i < total; i++) begin
			cost_to[AW'(i)] = 32'h7fff_ffff;
			closed[AW'(i)]  = 0;
		end
		cost_to[AW'(0)] = 0;
		forever begin
			best   = total;
			best_d = 32'h7fff_ffff;
			for (int i = 0; i < total; i++)
				if (!closed[AW'(i)] && cost_to[AW'(i)] < best_d) begin
					best_d = cost_to[AW'(i)];
					best   = i;
				end
			if (best >= total)
				break;
			closed[AW'(best)] = 1;
			r = best / cols;
			c = best % cols;
			for (k = 0; k < 4; k++) begin
				nr = r + dr[2'(k)];
				nc = c + dc[2'(k)];
				if (nr < 0 || nc < 0 || nr >= rows || nc >= cols)
					continue;
				nidx = nr * cols + nc;
				if (closed[AW'(nidx)])
					continue;
				hb   = int'(grid_heights[AW'(best)]);
				hn   = int'(grid_heights[AW'(nidx)]);
				cand = best_d + ((hb > hn) ? hb - hn : hn - hb);
				if (cand < cost_to[AW'(nidx)])
					cost_to[AW'(nidx)] = cand;
			end
		end
		return (cost_to[AW'(total-1)] > COST_SAT) ? COST_W'(COST_SAT) :
			COST_W'(cost_to[AW'(total-1)]);
	endfunction

	assign cost_pending = pend_q;
	assign in_beat      = in_valid && in_ready;
	assign out_beat     = out_valid && out_ready;
	assign push         = in_beat && last_cell;
	assign pop          = out_beat && (pend_q != 0);

	// Signals are stable mid-cycle; a beat seen here lands at the next rising edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos  <= '0;
			rows_reg   <= CFG_W'(1);
			cols_reg   <= CFG_W'(1);
			fail_count <= 0;
			head_q     <= '0;
			tail_q     <= '0;
			pend_q     <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ROW_COUNT)
					rows_reg <= cfg_data;
				else if (cfg_index == REG_COL_COUNT)
					cols_reg <= cfg_data;
			end
			if (in_beat) begin
				grid_heights[write_pos] = cell_height;
				if (last_cell) begin
					cost_fifo[tail_q] = climb_cost();
					tail_q    <= tail_q + 2'd1;
					write_pos <= '0;
				end else
					write_pos <= write_pos + AW'(1);
			end
			if (out_beat) begin
				if (pend_q == 0) begin
					$error("path_cost beat with nothing pending: actual %0d", path_cost);
					fail_count <= fail_count + 1;
				end else begin
					if (path_cost !== cost_fifo[head_q]) begin
						$error("path_cost mismatch: expected %0d, actual %0d",
							cost_fifo[head_q], path_cost);
						fail_count <= fail_count + 1;
					end
					head_q <= head_q + 2'd1;
				end
			end
			pend_q <= pend_q + int'(push) - int'(pop);
		end
	end

endmodule

/* tb/grid_min_climb_path_tb.sv */
// ----------------------------------------------------------------------------
// grid_min_climb_path_tb
// Loads height grids of many shapes, exact, short and overlong, under random
// gaps and output stalls, changing the grid size between searches. A checker
// beside the block predicts and compares every path cost.
// ----------------------------------------------------------------------------
module grid_min_climb_path_tb import gmcp_pkg::*;;

	localparam int CYCLE_LIMIT = 20000000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [HEIGHT_W-1:0]  cell_height;
	logic                 last_cell;
	logic                 out_valid;
	logic                 out_ready;
	logic [COST_W-1:0]    path_cost;
	int                   fail_count;
	int                   cost_pending;
	int                   cycle_count;
	int                   cells_sent;
	int                   loaded_prefix;
	int                   stall_left;
	bit                   no_gaps;
	bit                   out_fire;
	int                   cur_rows;
	int                   cur_cols;

	grid_min_climb_path u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cell_height(cell_height), .last_cell(last_cell),
		.out_valid(out_valid), .out_ready(out_ready), .path_cost(path_cost)
	);

	grid_min_climb_path_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cell_height(cell_height), .last_cell(last_cell),
		.out_valid(out_valid), .out_ready(out_ready), .path_cost(path_cost),
		.fail_count(fail_count), .cost_pending(cost_pending)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	// Hard stop on a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random stall after each cost beat
	always @(negedge clk) out_fire <= out_valid && out_ready;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 0;
			stall_left = 0;
		end else if (out_fire) begin
			stall_left = no_gaps ? 0 : $urandom_range(0, 13);
			out_ready <= (stall_left == 0);
		end else begin
			if (stall_left > 0)
				stall_left = stall_left - 1;
			out_ready <= (stall_left == 0);
		end
	end

	// One cell beat: optional gap, then hold until in_ready seen mid-cycle
	task automatic send_cell(input logic [HEIGHT_W-1:0] h, input logic lst);
		int  gap;
		bit  rdy;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1;
		cell_height <= h;
		last_cell   <= lst;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		cells_sent++;
	endtask

	// Drain, then write one register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		in_valid <= 0;
		@(negedge clk);
		while (cost_pending != 0) @(negedge clk);
		@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_ROW_COUNT)
			cur_rows = (val == 0) ? 1 : (val > DEF_MAX_ROWS ? DEF_MAX_ROWS : val);
		else
			cur_cols = (val == 0) ? 1 : (val > DEF_MAX_COLS ? DEF_MAX_COLS : val);
	endtask

	// Send count cells of random heights, last flag on the final one
	task automatic send_grid(input int count);
		for (int i = 0; i < count; i++)
			send_cell(HEIGHT_W'($urandom_range(0, HEIGHT_MAX)), i == count - 1);
		if (count > loaded_prefix)
			loaded_prefix = count;
	endtask

	initial begin
		int n, count, pick;
		arst_n      <= 0;
		cfg_we      <= 0;
		cfg_index   <= REG_ROW_COUNT;
		cfg_data    <= '0;
		in_valid    <= 0;
		cell_height <= '0;
		last_cell   <= 0;
		no_gaps     = 0;
		cells_sent  = 0;
		loaded_prefix = 0;
		cur_rows    = 1;
		cur_cols    = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: 1x1 after reset, height extremes
		send_cell(HEIGHT_W'(HEIGHT_MAX), 1'b1);
		send_cell(HEIGHT_W'(0), 1'b1);
		write_reg(REG_ROW_COUNT, 2);
		write_reg(REG_COL_COUNT, 2);
		send_cell(HEIGHT_W'(0), 1'b0);
		send_cell(HEIGHT_W'(HEIGHT_MAX), 1'b0);
		send_cell(HEIGHT_W'(HEIGHT_MAX), 1'b0);
		send_cell(HEIGHT_W'(0), 1'b1);
		loaded_prefix = 4;
		// short grid reuses earlier heights
		send_cell(HEIGHT_W'(9), 1'b1);
		// one row, then zero and oversize sizes clamp
		write_reg(REG_ROW_COUNT, 0);
		write_reg(REG_COL_COUNT, 5);
		send_cell(HEIGHT_W'(0), 1'b0);
		send_cell(HEIGHT_W'(HEIGHT_MAX), 1'b0);
		send_cell(HEIGHT_W'(3), 1'b0);
		send_cell(HEIGHT_W'(8), 1'b0);
		send_cell(HEIGHT_W'(1), 1'b0);
		send_cell(HEIGHT_W'(5), 1'b1);
		if (loaded_prefix < 6)
			loaded_prefix = 6;
		write_reg(REG_ROW_COUNT, 127);
		write_reg(REG_COL_COUNT, 1);
		send_grid(64);
		write_reg(REG_ROW_COUNT, 1);
		write_reg(REG_COL_COUNT, 64);
		send_grid(64);

		// Random grids: mostly small, a few tall or wide, some short or long
		while (cells_sent < 650) begin
			no_gaps = ($urandom_range(0, 5) == 0);
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				write_reg(REG_ROW_COUNT, $urandom_range(0, 127));
				write_reg(REG_COL_COUNT, $urandom_range(1, 2));
			end else if (pick == 1) begin
				write_reg(REG_ROW_COUNT, $urandom_range(1, 2));
				write_reg(REG_COL_COUNT, $urandom_range(0, 127));
			end else if (pick < 12) begin
				if ($urandom_range(0, 1))
					write_reg(REG_ROW_COUNT, $urandom_range(1, 6));
				else
					write_reg(REG_COL_COUNT, $urandom_range(1, 6));
			end
			n = cur_rows * cur_cols;
			pick = $urandom_range(0, 9);
			if (pick == 0 && n > 1 && loaded_prefix >= n)
				count = $urandom_range(1, n - 1);
			else if (pick == 1)
				count = n + $urandom_range(1, 5);
			else
				count = n;
			send_grid(count);
		end

		in_valid <= 0;
		no_gaps = 0;
		@(negedge clk);
		while (cost_pending != 0) @(negedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
